@@ rtl/core/skp_pkg.sv @@
// ----------------------------------------------------------------------------
// skp_pkg
// Types, constants and character classes shared by the skel stream parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package skp_pkg;

	localparam int MAX_DEPTH   = 255;
	localparam int LENGTH_BITS = 24;

	localparam int LEN_EFF_BITS = (LENGTH_BITS > 24) ? 24 : LENGTH_BITS;
	localparam logic [23:0] LEN_LIMIT   = 24'((64'd1 << LEN_EFF_BITS) - 64'd1);
	localparam logic [7:0]  DEPTH_LIMIT = 8'((MAX_DEPTH > 255) ? 255 : MAX_DEPTH);

	localparam logic [7:0] CH_OPEN   = 8'h28;
	localparam logic [7:0] CH_CLOSE  = 8'h29;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	typedef enum logic [2:0] {
		M_START,
		M_LIST,
		M_NAME,
		M_DIGITS,
		M_CONTENT,
		M_DONE,
		M_ERROR
	} mode_t;

	typedef enum logic [2:0] {
		ROLE_SPACE,
		ROLE_OPEN,
		ROLE_CLOSE,
		ROLE_NAME,
		ROLE_DIGIT,
		ROLE_SEP,
		ROLE_CONTENT,
		ROLE_IGNORED
	} role_t;

	typedef enum logic [1:0] {
		EV_NONE,
		EV_ENDS,
		EV_ENDED
	} atom_ev_t;

	typedef enum logic [1:0] {
		ST_PENDING,
		ST_COMPLETE,
		ST_ERROR
	} status_t;

	typedef struct packed {
		mode_t       mode;
		logic [7:0]  depth;
		logic [23:0] accum;
		logic [23:0] remain;
		logic [23:0] name_len;
	} parse_state_t;

	typedef struct packed {
		role_t       byte_role;
		logic [7:0]  nest_depth;
		atom_ev_t    atom_event;
		logic [23:0] atom_length;
		status_t     parse_status;
	} result_t;

	localparam parse_state_t STATE_RESET = '{
		mode: M_START, depth: 8'd0, accum: 24'd0, remain: 24'd0, name_len: 24'd0
	};

	function automatic logic is_space(input logic [7:0] c);
		return c inside {8'd9, 8'd10, 8'd12, 8'd13, 8'd32};
	endfunction

	function automatic logic is_bracket(input logic [7:0] c);
		return c inside {CH_OPEN, CH_CLOSE, CH_LBRACK, CH_RBRACK};
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c inside {[8'h41:8'h5A]}) || (c inside {[8'h61:8'h7A]});
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {[CH_ZERO:CH_NINE]};
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/skp_if.sv @@
// ----------------------------------------------------------------------------
// skp_byte_if / skp_token_if
// Valid/ready channels for raw frame bytes and per-byte token results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface skp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       frame_end;

	modport source (output valid, output in_byte, output frame_end, input ready);
	modport sink (input valid, input in_byte, input frame_end, output ready);
endinterface

interface skp_token_if;
	logic        valid;
	logic        ready;
	logic [2:0]  byte_role;
	logic [7:0]  nest_depth;
	logic [1:0]  atom_event;
	logic [23:0] atom_length;
	logic [1:0]  parse_status;

	modport source (output valid, output byte_role, output nest_depth, output atom_event,
		output atom_length, output parse_status, input ready);
	modport sink (input valid, input byte_role, input nest_depth, input atom_event,
		input atom_length, input parse_status, output ready);
endinterface

`default_nettype wire

@@ rtl/core/skp_step.sv @@
// ----------------------------------------------------------------------------
// skp_step
// Next-state and result logic of the parser for one byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module skp_step (
	input  skp_pkg::parse_state_t state,
	input  logic [7:0]            in_byte,
	input  logic                  frame_end,
	output skp_pkg::parse_state_t state_next,
	output skp_pkg::result_t      result
);
	import skp_pkg::*;

	typedef struct packed {
		role_t      role;
		mode_t      mode;
		logic [7:0] depth;
		logic       name_start;
		logic       accum_start;
	} elem_t;

	// byte where a new element, or inside a list a space or close, may come
	function automatic elem_t element(input mode_t mode, input logic [7:0] depth,
		input logic [7:0] c);
		elem_t e;
		logic [7:0] dec;
		dec = depth - 8'd1;
		e = '{role: ROLE_IGNORED, mode: M_ERROR, depth: depth, name_start: 1'b0,
			accum_start: 1'b0};
		if (mode == M_LIST && is_space(c)) begin
			e.role = ROLE_SPACE;
			e.mode = M_LIST;
		end else if (mode == M_LIST && c == CH_CLOSE) begin
			e.role  = ROLE_CLOSE;
			e.depth = dec;
			e.mode  = (dec == 8'd0) ? M_DONE : M_LIST;
		end else if (c == CH_OPEN) begin
			if (depth < DEPTH_LIMIT) begin
				e.role  = ROLE_OPEN;
				e.depth = depth + 8'd1;
				e.mode  = M_LIST;
			end
		end else if (is_letter(c)) begin
			e.role       = ROLE_NAME;
			e.mode       = M_NAME;
			e.name_start = 1'b1;
		end else if (is_digit(c)) begin
			e.role        = ROLE_DIGIT;
			e.mode        = M_DIGITS;
			e.accum_start = 1'b1;
		end
		return e;
	endfunction

	elem_t        el;
	mode_t        el_mode;
	parse_state_t nxt;
	role_t        role;
	atom_ev_t     ev;
	logic [23:0]  alen;
	logic [27:0]  acc_wide;
	logic [27:0]  acc_mul;
	status_t      status;

	// a name ended by a bracket or space hands that byte back to the list
	assign el_mode  = (state.mode == M_NAME) ? M_LIST : state.mode;
	assign el       = element(el_mode, state.depth, in_byte);
	assign acc_wide = {4'd0, state.accum};
	assign acc_mul  = (acc_wide << 3) + (acc_wide << 1) + {24'd0, in_byte[3:0]};

	always_comb begin
		nxt  = state;
		role = ROLE_IGNORED;
		ev   = EV_NONE;
		alen = 24'd0;

		case (state.mode)
			M_START, M_LIST: begin
				role      = el.role;
				nxt.mode  = el.mode;
				nxt.depth = el.depth;
				if (el.name_start)
					nxt.name_len = 24'd1;
				if (el.accum_start)
					nxt.accum = {20'd0, in_byte[3:0]};
			end
			M_NAME: begin
				if (is_space(in_byte) || is_bracket(in_byte)) begin
					ev           = EV_ENDED;
					alen         = state.name_len;
					nxt.name_len = 24'd0;
					if (state.depth == 8'd0) begin
						nxt.mode = M_DONE;
					end else begin
						role      = el.role;
						nxt.mode  = el.mode;
						nxt.depth = el.depth;
					end
				end else if (state.name_len == LEN_LIMIT) begin
					nxt.mode = M_ERROR;
				end else begin
					nxt.name_len = state.name_len + 24'd1;
					role         = ROLE_NAME;
				end
			end
			M_DIGITS: begin
				if (is_digit(in_byte)) begin
					if (acc_mul > {4'd0, LEN_LIMIT}) begin
						nxt.mode = M_ERROR;
					end else begin
						nxt.accum = acc_mul[23:0];
						role      = ROLE_DIGIT;
					end
				end else if (is_space(in_byte)) begin
					role = ROLE_SEP;
					if (state.accum == 24'd0) begin
						ev       = EV_ENDS;
						nxt.mode = (state.depth == 8'd0) ? M_DONE : M_LIST;
					end else begin
						nxt.remain = state.accum;
						nxt.mode   = M_CONTENT;
					end
				end else begin
					nxt.mode = M_ERROR;
				end
			end
			M_CONTENT: begin
				role       = ROLE_CONTENT;
				nxt.remain = state.remain - 24'd1;
				if (state.remain == 24'd1) begin
					ev       = EV_ENDS;
					alen     = state.accum;
					nxt.mode = (state.depth == 8'd0) ? M_DONE : M_LIST;
				end
			end
			default: begin
				role = ROLE_IGNORED;
			end
		endcase

		// frame end closes an open name and forces a final verdict
		if (frame_end) begin
			if (nxt.mode == M_NAME) begin
				ev       = EV_ENDS;
				alen     = nxt.name_len;
				nxt.mode = (nxt.depth == 8'd0) ? M_DONE : M_ERROR;
			end else if (nxt.mode != M_DONE) begin
				nxt.mode = M_ERROR;
			end
		end

		case (nxt.mode)
			M_DONE:  status = ST_COMPLETE;
			M_ERROR: status = ST_ERROR;
			default: status = ST_PENDING;
		endcase
	end

	assign result = '{byte_role: role, nest_depth: nxt.depth, atom_event: ev,
		atom_length: alen, parse_status: status};
	assign state_next = frame_end ? STATE_RESET : nxt;

endmodule

`default_nettype wire

@@ rtl/core/skel_stream_parser_unit.sv @@
// ----------------------------------------------------------------------------
// skel_stream_parser_unit
// Streaming checker of one skel expression per frame, one token per byte.
// ----------------------------------------------------------------------------
// Usage:
//   bytes  : input channel, one raw byte per transaction; frame_end marks the
//            last byte of a frame.
//   tokens : output channel, exactly one transaction per input byte carrying
//            its role, nesting depth after it, atom end event and length, and
//            the sticky status (pending, complete, error).
//   A byte's token comes from registers: the byte is captured in an input
//   register, the parser step and the state update happen between it and
//   the result register, which loads when that register is empty or taken.
//   Throughput is one byte per cycle while tokens does not stall, set by the
//   state feedback around the step logic.
//   When tokens stalls, the result register holds and the input register
//   still takes one more byte; bytes.ready drops only once both are full.
//   Asynchronous reset empties both registers and returns the parser to
//   the start of a frame. The parser also returns there after every byte
//   that carries frame_end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module skel_stream_parser_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	skp_byte_if.sink   bytes,
	skp_token_if.source tokens
);
	import skp_pkg::*;

	logic         valid_s1_q;
	logic [7:0]   byte_s1;
	logic         last_s1;
	logic         valid_s2_q;
	result_t      result_s2;
	parse_state_t state_q;
	parse_state_t state_next;
	result_t      result_next;
	logic         advance;

	assign advance     = valid_s1_q && (!valid_s2_q || tokens.ready);
	assign bytes.ready = !valid_s1_q || advance;

	skp_step u_step (
		.state      (state_q),
		.in_byte    (byte_s1),
		.frame_end  (last_s1),
		.state_next (state_next),
		.result     (result_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
			valid_s2_q <= 1'b0;
			state_q    <= STATE_RESET;
		end else begin
			if (bytes.ready)
				valid_s1_q <= bytes.valid;
			if (!valid_s2_q || tokens.ready)
				valid_s2_q <= valid_s1_q;
			if (advance)
				state_q <= state_next;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			byte_s1 <= bytes.in_byte;
			last_s1 <= bytes.frame_end;
		end
		if (advance)
			result_s2 <= result_next;
	end

	assign tokens.valid        = valid_s2_q;
	assign tokens.byte_role    = result_s2.byte_role;
	assign tokens.nest_depth   = result_s2.nest_depth;
	assign tokens.atom_event   = result_s2.atom_event;
	assign tokens.atom_length  = result_s2.atom_length;
	assign tokens.parse_status = result_s2.parse_status;

endmodule

`default_nettype wire

@@ rtl/core/skp_checker.sv @@
// ----------------------------------------------------------------------------
// skp_checker
// Port-level checks on the token stream of the skel stream parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module skp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  byte_role,
	input wire logic [7:0]  nest_depth,
	input wire logic [1:0]  atom_event,
	input wire logic [23:0] atom_length,
	input wire logic [1:0]  parse_status
);
	import skp_pkg::*;

	// stalled token transaction keeps its payload
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(byte_role) &&
		$stable(nest_depth) && $stable(atom_event) && $stable(atom_length) &&
		$stable(parse_status))
		else $error("token payload changed while stalled");

	a_len_no_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && atom_event == EV_NONE |-> atom_length == 24'd0)
		else $error("atom length without atom event");

	// an ignored byte never ends an atom itself
	a_ignored_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_role == ROLE_IGNORED |-> atom_event != EV_ENDS)
		else $error("ignored byte reports atom end");

	a_open_depth: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_role == ROLE_OPEN |-> nest_depth != 8'd0)
		else $error("open bracket at depth zero");

	a_complete_depth: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && parse_status == ST_COMPLETE |-> nest_depth == 8'd0)
		else $error("complete expression with open lists");

endmodule

bind skel_stream_parser_unit skp_checker u_skp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (tokens.valid),
	.out_ready    (tokens.ready),
	.byte_role    (tokens.byte_role),
	.nest_depth   (tokens.nest_depth),
	.atom_event   (tokens.atom_event),
	.atom_length  (tokens.atom_length),
	.parse_status (tokens.parse_status)
);

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for skel_stream_parser_unit. Frames of bytes (directed
// corner cases, very deep nesting, random well-formed expressions, corrupted,
// cut-short and noise frames) go in through the byte channel with random gaps.
// An in-bench parser model predicts every token. Tokens are taken with random
// back-pressure and compared field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import skp_pkg::*;

	localparam logic [7:0] CH_TAB  = 8'd9;
	localparam logic [7:0] CH_LF   = 8'd10;
	localparam logic [7:0] CH_FF   = 8'd12;
	localparam logic [7:0] CH_CR   = 8'd13;
	localparam logic [7:0] CH_SP   = 8'd32;
	localparam logic [7:0] CH_UP_A = 8'h41;
	localparam logic [7:0] CH_UP_Z = 8'h5A;
	localparam logic [7:0] CH_LO_A = 8'h61;
	localparam logic [7:0] CH_LO_Z = 8'h7A;

	localparam int ITEM_COUNT   = 1650;
	localparam int CALM_TAIL    = 150;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} frame_byte_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	skp_byte_if  byte_ch();
	skp_token_if tok_ch();

	skel_stream_parser_unit dut (
		.clk   (clk),
		.arst_n(arst_n),
		.bytes (byte_ch),
		.tokens(tok_ch)
	);

	logic       feed_valid = 1'b0;
	logic [7:0] feed_byte = 8'd0;
	logic       feed_last = 1'b0;
	logic       tok_ready = 1'b0;
	logic       calm = 1'b0;

	assign byte_ch.valid     = feed_valid;
	assign byte_ch.in_byte   = feed_byte;
	assign byte_ch.frame_end = feed_last;
	assign tok_ch.ready      = tok_ready;

	frame_byte_t byte_q[$];
	result_t     token_q[$];
	logic [7:0]  frame_q[$];
	frame_byte_t head;
	result_t     oldest_token;
	int          gap_left = 0;
	int          stall_left = 0;
	int          mismatches = 0;

	// parser model state
	mode_t       scan_mode = M_START;
	logic [7:0]  scan_depth = 8'd0;
	logic [23:0] digit_value = 24'd0;
	logic [23:0] body_left = 24'd0;
	logic [23:0] word_len = 24'd0;

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#10_000_000;
		$display("tb: FAIL");
		$finish;
	end

	function automatic logic is_blank(input logic [7:0] c);
		return c == CH_TAB || c == CH_LF || c == CH_FF || c == CH_CR || c == CH_SP;
	endfunction

	function automatic logic is_brace(input logic [7:0] c);
		return c == CH_OPEN || c == CH_CLOSE || c == CH_LBRACK || c == CH_RBRACK;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
	endfunction

	function automatic logic is_numeral(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic void finish_atom();
		if (scan_depth == 8'd0)
			scan_mode = M_DONE;
		else
			scan_mode = M_LIST;
	endfunction

	// byte where a new element, or inside a list a space or close, may come
	function automatic role_t start_element(input logic [7:0] c);
		if (scan_mode == M_LIST && is_blank(c))
			return ROLE_SPACE;
		if (scan_mode == M_LIST && c == CH_CLOSE) begin
			scan_depth = scan_depth - 8'd1;
			finish_atom();
			return ROLE_CLOSE;
		end
		if (c == CH_OPEN) begin
			if (scan_depth >= DEPTH_LIMIT) begin
				scan_mode = M_ERROR;
				return ROLE_IGNORED;
			end
			scan_depth = scan_depth + 8'd1;
			scan_mode = M_LIST;
			return ROLE_OPEN;
		end
		if (is_alpha(c)) begin
			word_len = 24'd1;
			scan_mode = M_NAME;
			return ROLE_NAME;
		end
		if (is_numeral(c)) begin
			digit_value = 24'(c - CH_ZERO);
			scan_mode = M_DIGITS;
			return ROLE_DIGIT;
		end
		scan_mode = M_ERROR;
		return ROLE_IGNORED;
	endfunction

	function automatic result_t predict_token(input logic [7:0] c, input logic last);
		result_t     r;
		role_t       role;
		atom_ev_t    ev;
		logic [23:0] alen;
		logic [31:0] grown;
		role = ROLE_IGNORED;
		ev = EV_NONE;
		alen = 24'd0;
		case (scan_mode)
			M_START, M_LIST: begin
				role = start_element(c);
			end
			M_NAME: begin
				if (is_blank(c) || is_brace(c)) begin
					ev = EV_ENDED;
					alen = word_len;
					word_len = 24'd0;
					if (scan_depth == 8'd0) begin
						scan_mode = M_DONE;
					end else begin
						scan_mode = M_LIST;
						role = start_element(c);
					end
				end else if ({1'b0, word_len} + 25'd1 > {1'b0, LEN_LIMIT}) begin
					scan_mode = M_ERROR;
				end else begin
					word_len = word_len + 24'd1;
					role = ROLE_NAME;
				end
			end
			M_DIGITS: begin
				if (is_numeral(c)) begin
					grown = {8'd0, digit_value} * 32'd10 + 32'(c - CH_ZERO);
					if (grown > {8'd0, LEN_LIMIT}) begin
						scan_mode = M_ERROR;
					end else begin
						digit_value = grown[23:0];
						role = ROLE_DIGIT;
					end
				end else if (is_blank(c)) begin
					role = ROLE_SEP;
					if (digit_value == 24'd0) begin
						ev = EV_ENDS;
						finish_atom();
					end else begin
						body_left = digit_value;
						scan_mode = M_CONTENT;
					end
				end else begin
					scan_mode = M_ERROR;
				end
			end
			M_CONTENT: begin
				role = ROLE_CONTENT;
				body_left = body_left - 24'd1;
				if (body_left == 24'd0) begin
					ev = EV_ENDS;
					alen = digit_value;
					finish_atom();
				end
			end
			default: begin
				role = ROLE_IGNORED;
			end
		endcase

		if (last) begin
			if (scan_mode == M_NAME) begin
				ev = EV_ENDS;
				alen = word_len;
				if (scan_depth == 8'd0)
					scan_mode = M_DONE;
				else
					scan_mode = M_ERROR;
			end else if (scan_mode != M_DONE) begin
				scan_mode = M_ERROR;
			end
		end

		r.byte_role = role;
		r.nest_depth = scan_depth;
		r.atom_event = ev;
		r.atom_length = alen;
		if (scan_mode == M_DONE)
			r.parse_status = ST_COMPLETE;
		else if (scan_mode == M_ERROR)
			r.parse_status = ST_ERROR;
		else
			r.parse_status = ST_PENDING;

		if (last) begin
			scan_mode = M_START;
			scan_depth = 8'd0;
			digit_value = 24'd0;
			body_left = 24'd0;
			word_len = 24'd0;
		end
		return r;
	endfunction

	function automatic void compare_field(string field, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("token field %s: expected %0d, got %0d", field, want, got);
			mismatches++;
		end
	endfunction

	// ---------------- frame building ----------------

	function automatic void put_byte(input logic [7:0] b);
		frame_q.push_back(b);
	endfunction

	function automatic void put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endfunction

	function automatic logic [7:0] pick_space();
		case ($urandom_range(0, 4))
			0: return CH_TAB;
			1: return CH_LF;
			2: return CH_FF;
			3: return CH_CR;
			default: return CH_SP;
		endcase
	endfunction

	function automatic void put_name();
		logic [7:0] b;
		if ($urandom_range(0, 1))
			put_byte(CH_UP_A + 8'($urandom_range(0, 25)));
		else
			put_byte(CH_LO_A + 8'($urandom_range(0, 25)));
		repeat ($urandom_range(0, 5)) begin
			do
				b = 8'($urandom_range(0, 255));
			while (is_blank(b) || is_brace(b));
			put_byte(b);
		end
	endfunction

	function automatic void put_atom(input int unsigned len);
		repeat (($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0)
			put_byte(CH_ZERO);
		put_text($sformatf("%0d", len));
		put_byte(pick_space());
		repeat (len)
			put_byte(8'($urandom_range(0, 255)));
	endfunction

	function automatic void build_expression();
		int depth;
		int steps;
		int kind;
		bit after_name;
		depth = 0;
		steps = 0;
		after_name = 0;
		do begin
			kind = $urandom_range(0, 9);
			if (depth > 0 && (kind < 3 || steps > 30)) begin
				if ($urandom_range(0, 3) == 0)
					put_byte(pick_space());
				put_byte(CH_CLOSE);
				depth--;
				after_name = 0;
			end else if (kind < 6 && depth < 6 && steps < 30) begin
				if (depth > 0 && $urandom_range(0, 3) == 0)
					put_byte(pick_space());
				put_byte(CH_OPEN);
				depth++;
				after_name = 0;
			end else begin
				// a name runs on until a space or bracket
				if (after_name || (depth > 0 && $urandom_range(0, 2) == 0))
					put_byte(pick_space());
				if ($urandom_range(0, 1)) begin
					put_name();
					after_name = 1;
				end else begin
					if ($urandom_range(0, 19) == 0)
						put_atom($urandom_range(0, 300));
					else
						put_atom($urandom_range(0, 6));
					after_name = 0;
				end
			end
			steps++;
		end while (depth > 0);
	endfunction

	function automatic void seal_frame();
		frame_byte_t fb;
		for (int i = 0; i < frame_q.size(); i++) begin
			fb.data = frame_q[i];
			fb.last = (i == frame_q.size() - 1);
			byte_q.push_back(fb);
		end
		frame_q.delete();
	endfunction

	// ---------------- stimulus and end of run ----------------

	initial begin
		int pick;
		int cut;

		put_text(" ");        seal_frame();
		put_text(")");        seal_frame();
		put_text("a");        seal_frame();
		put_text("ab x");     seal_frame();
		put_text("(a[");      seal_frame();
		put_text("0 ");       seal_frame();
		put_text("2 ");
		put_byte(8'h00);
		put_byte(8'hFF);
		seal_frame();
		put_text("1x");       seal_frame();
		put_text("16777216"); seal_frame();

		// nesting limit: the last open fails, then a full-depth list closes cleanly
		repeat (256) put_byte(CH_OPEN);
		seal_frame();
		repeat (255) put_byte(CH_OPEN);
		repeat (255) put_byte(CH_CLOSE);
		seal_frame();

		while (byte_q.size() < ITEM_COUNT) begin
			pick = $urandom_range(0, 19);
			if (pick == 18) begin
				repeat ($urandom_range(1, 6))
					put_byte(8'($urandom_range(0, 255)));
			end else if (pick == 19) begin
				put_text($sformatf("%0d", $urandom_range(16777216, 99999999)));
				if ($urandom_range(0, 1)) begin
					put_byte(pick_space());
					put_byte(8'($urandom_range(0, 255)));
				end
			end else begin
				build_expression();
				if (pick >= 16) begin
					cut = $urandom_range(1, frame_q.size());
					while (frame_q.size() > cut)
						void'(frame_q.pop_back());
				end else if (pick >= 13) begin
					frame_q[$urandom_range(0, frame_q.size() - 1)] = 8'($urandom_range(0, 255));
				end else if ($urandom_range(0, 3) == 0) begin
					repeat ($urandom_range(1, 3))
						put_byte(8'($urandom_range(0, 255)));
				end
			end
			seal_frame();
		end

		while (byte_q.size() != 0 || feed_valid || token_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

	// byte driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feed_valid <= 1'b0;
			feed_byte <= 8'd0;
			feed_last <= 1'b0;
		end else begin
			if (byte_ch.valid && byte_ch.ready)
				token_q.push_back(predict_token(byte_ch.in_byte, byte_ch.frame_end));
			if (!byte_ch.valid || byte_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					feed_valid <= 1'b0;
				end else if (byte_q.size() > 0) begin
					head = byte_q.pop_front();
					feed_valid <= 1'b1;
					feed_byte <= head.data;
					feed_last <= head.last;
					if (byte_q.size() >= CALM_TAIL && $urandom_range(0, 7) == 0)
						gap_left = $urandom_range(1, 12);
				end else begin
					feed_valid <= 1'b0;
				end
			end
			calm <= byte_q.size() < CALM_TAIL;
		end
	end

	// token monitor with back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_ready <= 1'b0;
		end else begin
			if (tok_ch.valid && tok_ch.ready) begin
				if (token_q.size() == 0) begin
					$error("token transaction with no byte waiting for it");
					mismatches++;
				end else begin
					oldest_token = token_q.pop_front();
					compare_field("byte_role", oldest_token.byte_role, tok_ch.byte_role);
					compare_field("nest_depth", oldest_token.nest_depth, tok_ch.nest_depth);
					compare_field("atom_event", oldest_token.atom_event, tok_ch.atom_event);
					compare_field("atom_length", oldest_token.atom_length, tok_ch.atom_length);
					compare_field("parse_status", oldest_token.parse_status,
						tok_ch.parse_status);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				tok_ready <= 1'b0;
			end else begin
				tok_ready <= 1'b1;
				if (!calm && $urandom_range(0, 7) == 0)
					stall_left = $urandom_range(1, 12);
			end
		end
	end

endmodule
